// ----- rtl/tmcs_pkg.sv -----
// Shared constants, register codes and controller/datapath types for the current sense filter.
package tmcs_pkg;

   localparam int WINDOW_DEF      = 24;
   localparam int SAMPLE_BITS_DEF = 12;

   localparam int CODE_BITS      = 12;
   localparam int CURRENT_BITS   = 16;
   localparam int GAIN_BITS      = 32;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SENSOR_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_CODE   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN        = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_DIRECT   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_INVERTED = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_OFF      = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_RESET      = MODE_INVERTED;
   localparam logic [CODE_BITS-1:0] ZERO_CODE_RESET = 12'd1980;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET      = 32'd211205;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic win_load;
      logic scan_step;
      logic trim;
      logic div_step;
      logic mul;
      logic out_load;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic out_full;
      logic out_taken;
   } ctrl_stat_type;

endpackage

// ----- rtl/tmcs_if.sv -----
// Valid/ready channel interfaces for the sample input and the result output.
interface tmcs_req_if #(
   parameter int SAMPLE_BITS = tmcs_pkg::SAMPLE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tmcs_rsp_if ();
   logic                              valid;
   logic                              ready;
   logic [tmcs_pkg::CODE_BITS-1:0]    filtered_code;
   logic [tmcs_pkg::CURRENT_BITS-1:0] current_ma;

   modport source (output valid, output filtered_code, output current_ma, input ready);
   modport sink   (input valid, input filtered_code, input current_ma, output ready);
endinterface

// ----- rtl/tmcs_ctrl.sv -----
// Sequencing state machine: window update, rotating scan, trim, divide, scale, output.
module tmcs_ctrl #(
   parameter int WINDOW = tmcs_pkg::WINDOW_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  tmcs_pkg::ctrl_stat_type stat,
   output tmcs_pkg::ctrl_cmd_type  cmd
);
   import tmcs_pkg::*;

   localparam int CNT_BITS = $clog2(WINDOW);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SCAN = 6'b000010,
      S_TRIM = 6'b000100,
      S_DIV  = 6'b001000,
      S_MUL  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                scan_last;

   assign scan_last = (cnt_ff == CNT_BITS'(WINDOW - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      in_ready = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.win_load = 1'b1;
               cnt_in       = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (scan_last) begin
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            cmd.trim = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Wait here only while the previous result is still unclaimed.
            if (!stat.out_full || stat.out_taken) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!stat.out_full || stat.out_taken))
      else $error("result loaded over an unclaimed result");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == S_SCAN && cnt_ff == '0))
      else $error("accepted sample did not start a scan");

   a_scan_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && scan_last) |=> (state_ff == S_TRIM))
      else $error("scan did not end after the full window");

endmodule

// ----- rtl/tmcs_dp.sv -----
// Datapath: sample window, scan accumulators, reciprocal divider, gain multiply and result register.
module tmcs_dp #(
   parameter int WINDOW      = tmcs_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = tmcs_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [SAMPLE_BITS-1:0]               in_sample,
   input  logic                                 csr_we,
   input  logic [tmcs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tmcs_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  tmcs_pkg::ctrl_cmd_type               cmd,
   output tmcs_pkg::ctrl_stat_type              stat,
   tmcs_rsp_if.source                           rsp_chan
);
   import tmcs_pkg::*;

   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW + 1);
   localparam int TRIM_DIV  = WINDOW - 2;
   localparam int X_BITS    = (SAMPLE_BITS > CODE_BITS) ? SAMPLE_BITS : CODE_BITS;
   localparam int PROD_BITS = X_BITS + GAIN_BITS;
   // The reciprocal is rounded up with enough fraction bits that the quotient is exact
   // for every sum that fits in SUM_BITS.
   localparam int RECIP_SHIFT = SUM_BITS + $clog2(TRIM_DIV);
   localparam int RECIP_BITS  = SUM_BITS + 2;
   localparam int QPROD_BITS  = SUM_BITS + RECIP_BITS;
   localparam longint unsigned RECIP_VAL =
      ((longint'(1) << RECIP_SHIFT) + longint'(TRIM_DIV) - 1) / longint'(TRIM_DIV);
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);

   logic [SAMPLE_BITS-1:0]  win_ff [WINDOW];
   logic [SAMPLE_BITS-1:0]  win_in [WINDOW];
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]  hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0]  lo_ff, lo_in;
   logic [SUM_BITS-1:0]     rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]  q_ff, q_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic [CODE_BITS-1:0]    code_ff, code_in;
   logic [CURRENT_BITS-1:0] cur_ff, cur_in;
   logic                    valid_ff, valid_in;
   logic [MODE_BITS-1:0]    mode_ff, mode_in;
   logic [CODE_BITS-1:0]    zc_ff, zc_in;
   logic [GAIN_BITS-1:0]    gain_ff, gain_in;

   logic [X_BITS-1:0]       mean_x;
   logic [X_BITS-1:0]       zc_x;
   logic [X_BITS-1:0]       x_w;
   logic [QPROD_BITS-1:0]   qprod;
   logic                    taken;

   assign taken          = valid_ff && rsp_chan.ready;
   assign stat.out_full  = valid_ff;
   assign stat.out_taken = taken;

   assign mean_x = X_BITS'(q_ff);
   assign zc_x   = X_BITS'(zc_ff);
   assign qprod  = QPROD_BITS'(rem_ff) * QPROD_BITS'(RECIP);

   always_comb begin
      case (mode_ff)
         MODE_DIRECT:   x_w = mean_x;
         MODE_INVERTED: x_w = (mean_x < zc_x) ? (zc_x - mean_x) : '0;
         default:       x_w = '0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      zc_in   = zc_ff;
      gain_in = gain_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SENSOR_MODE: mode_in = csr_wdata[MODE_BITS-1:0];
            CSR_ZERO_CODE:   zc_in   = csr_wdata[CODE_BITS-1:0];
            CSR_GAIN:        gain_in = csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      win_in   = win_ff;
      sum_in   = sum_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      prod_in  = prod_ff;
      code_in  = code_ff;
      cur_in   = cur_ff;
      valid_in = valid_ff;

      // Shift in the new sample; an empty (zero) entry takes the new sample as it moves.
      if (cmd.win_load) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            win_in[i] = (win_ff[i + 1] == '0) ? in_sample : win_ff[i + 1];
         end
         win_in[WINDOW - 1] = in_sample;
         sum_in = '0;
         hi_in  = '0;
         lo_in  = '1;
      end

      // The scan reads entry 0 and rotates, so a full pass restores the window order.
      if (cmd.scan_step) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[WINDOW - 1] = win_ff[0];
         sum_in = sum_ff + SUM_BITS'(win_ff[0]);
         if (win_ff[0] > hi_ff) begin
            hi_in = win_ff[0];
         end
         if (win_ff[0] < lo_ff) begin
            lo_in = win_ff[0];
         end
      end

      if (cmd.trim) begin
         rem_in = sum_ff - SUM_BITS'(hi_ff) - SUM_BITS'(lo_ff);
      end

      // Division by the trimmed count through multiplication by its reciprocal.
      if (cmd.div_step) begin
         q_in = qprod[RECIP_SHIFT +: SAMPLE_BITS];
      end

      if (cmd.mul) begin
         prod_in = PROD_BITS'(x_w) * PROD_BITS'(gain_ff);
      end

      if (taken) begin
         valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         code_in  = mean_x[CODE_BITS-1:0];
         cur_in   = (|prod_ff[PROD_BITS-1:GAIN_FRAC_BITS+CURRENT_BITS]) ? '1 :
                    prod_ff[GAIN_FRAC_BITS+CURRENT_BITS-1:GAIN_FRAC_BITS];
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         valid_ff <= 1'b0;
         mode_ff  <= MODE_RESET;
         zc_ff    <= ZERO_CODE_RESET;
         gain_ff  <= GAIN_RESET;
      end else begin
         win_ff   <= win_in;
         valid_ff <= valid_in;
         mode_ff  <= mode_in;
         zc_ff    <= zc_in;
         gain_ff  <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
      code_ff <= code_in;
      cur_ff  <= cur_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.filtered_code = code_ff;
   assign rsp_chan.current_ma    = cur_ff;

endmodule

// ----- rtl/trimmed_mean_current_sense.sv -----
// Top level of the trimmed-mean current sense filter.
//
//   channel    direction  handshake            payload
//   req_chan   in         valid/ready          sample
//   rsp_chan   out        valid/ready          filtered_code, current_ma
//   csr_*      in         write enable only    csr_index, csr_wdata
//
// Each sample passes through these steps in order: shift the window, the rotating
// scan that sums and finds the extremes, trim, divide by multiplying with the
// reciprocal, multiply by the gain, and load the result.
// Reset empties the window and loads the default mode, zero code and gain.
// A finished result waits in the output register; the next sample is taken meanwhile and
// its result holds in the last step until the earlier one has been transferred.
module trimmed_mean_current_sense #(
   parameter int WINDOW      = tmcs_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = tmcs_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   tmcs_req_if.sink                            req_chan,
   tmcs_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [tmcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tmcs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tmcs_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   logic          in_ready;

   assign req_chan.ready = in_ready;

   tmcs_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (in_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   tmcs_dp #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .in_sample (req_chan.sample),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_chan  (rsp_chan)
   );

endmodule
